FILE: src/bdq_pkg.sv
// Shared types and codes for the bounded deque unit.
package bdq_pkg;

  typedef enum logic [3:0] {
    OP_ADD_FRONT  = 4'd0,
    OP_ADD_BACK   = 4'd1,
    OP_DEL_VALUE  = 4'd2,
    OP_DEL_FIRST  = 4'd3,
    OP_DEL_LAST   = 4'd4,
    OP_EMIT_FIRST = 4'd5,
    OP_EMIT_LAST  = 4'd6,
    OP_EMIT_ALL   = 4'd7,
    OP_CLEAR      = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {WR_NONE, WR_FRONT, WR_BACK, WR_SHIFT} wr_sel_e;
  typedef enum logic [1:0] {LEN_HOLD, LEN_INC, LEN_DEC, LEN_CLR} len_op_e;
  typedef enum logic [1:0] {FR_HOLD, FR_DEC, FR_INC, FR_CLR} front_op_e;
  typedef enum logic [1:0] {POS_HOLD, POS_ZERO, POS_EMIT, POS_INC} pos_op_e;

  // controller -> datapath
  typedef struct packed {
    logic      latch;
    logic      rd_en;
    logic      rd_next;
    wr_sel_e   wr_sel;
    len_op_e   len_op;
    front_op_e front_op;
    pos_op_e   pos_op;
    logic      out_load;
    logic      out_entry;
    status_e   out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  kind;
    logic empty;
    logic full;
    logic emit_none;
    logic match;
    logic pos_zero;
    logic scan_end;
    logic emit_end;
    logic out_free;
  } sts_t;

endpackage

FILE: src/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bdq_datapath.sv
// Datapath: entry store, front/length/position registers and result register.
module bdq_datapath import bdq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         in_kind_i,
  input  logic signed [31:0] in_value_i,
  input  logic [6:0]         in_count_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_item_o,
  output logic               out_has_item_o,
  output logic [1:0]         out_status_o,
  output logic               out_last_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW:0]   CAP_W   = (LW+1)'(CAPACITY);
  localparam logic [LW-1:0] CAP_L   = LW'(CAPACITY);
  localparam logic [6:0]    CAP_CNT = 7'(CAPACITY);
  localparam logic [AW-1:0] TOP_SLOT = AW'(CAPACITY - 1);

  // circular slot of a list position
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [LW-1:0] off);
    logic [LW:0] sum;
    sum = (LW+1)'(base) + (LW+1)'(off);
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[AW-1:0];
  endfunction

  op_e               kind_q;
  logic signed [31:0] value_q;
  logic [6:0]        count_q;
  logic [AW-1:0]     front_q, front_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic [LW-1:0]     end_q, end_d;

  logic              out_valid_q;
  logic signed [31:0] item_q;
  logic              has_item_q;
  status_e           status_q;
  logic              last_q;

  logic [6:0]        cnt_sat;
  logic [LW-1:0]     k, emit_n, emit_start, pos_plus;
  logic [AW-1:0]     front_dec, rd_addr, wr_addr;
  logic [31:0]       wr_data, rd_data;
  logic              wr_en, out_free;

  assign cnt_sat    = (count_q > CAP_CNT) ? CAP_CNT : count_q;
  assign k          = (LW'(cnt_sat) < len_q) ? LW'(cnt_sat) : len_q;
  assign emit_n     = (kind_q == OP_EMIT_ALL) ? len_q : k;
  assign emit_start = (kind_q == OP_EMIT_LAST) ? (len_q - k) : '0;
  assign pos_plus   = pos_q + LW'(1);
  assign front_dec  = (front_q == '0) ? TOP_SLOT : (front_q - AW'(1));
  assign rd_addr    = slot(front_q, cmd_i.rd_next ? pos_plus : pos_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = slot(front_q, pos_q);
    wr_data = rd_data;
    case (cmd_i.wr_sel)
      WR_FRONT: begin
        wr_addr = front_dec;
        wr_data = value_q;
      end
      WR_BACK: begin
        wr_addr = slot(front_q, len_q);
        wr_data = value_q;
      end
      WR_SHIFT: begin
        wr_addr = slot(front_q, pos_q);
        wr_data = rd_data;
      end
      default: wr_en = 1'b0;
    endcase
  end

  bdq_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_comb begin
    len_d = len_q;
    case (cmd_i.len_op)
      LEN_INC: len_d = len_q + LW'(1);
      LEN_DEC: len_d = len_q - LW'(1);
      LEN_CLR: len_d = '0;
      default: len_d = len_q;
    endcase
    front_d = front_q;
    case (cmd_i.front_op)
      FR_DEC:  front_d = front_dec;
      FR_INC:  front_d = slot(front_q, LW'(1));
      FR_CLR:  front_d = '0;
      default: front_d = front_q;
    endcase
    pos_d = pos_q;
    end_d = end_q;
    case (cmd_i.pos_op)
      POS_ZERO: pos_d = '0;
      POS_EMIT: begin
        pos_d = emit_start;
        end_d = emit_start + emit_n;
      end
      POS_INC:  pos_d = pos_plus;
      default:  pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= op_e'(in_kind_i);
      value_q <= in_value_i;
      count_q <= in_count_i;
    end
    if (cmd_i.out_load) begin
      item_q     <= cmd_i.out_entry ? $signed(rd_data) : '0;
      has_item_q <= cmd_i.out_entry;
      status_q   <= cmd_i.out_status;
      last_q     <= cmd_i.out_entry ? sts_o.emit_end : 1'b1;
    end
  end

  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.empty     = (len_q == '0);
    sts_o.full      = (len_q == CAP_L);
    sts_o.emit_none = (emit_n == '0);
    sts_o.match     = (rd_data == value_q);
    sts_o.pos_zero  = (pos_q == '0);
    sts_o.scan_end  = (pos_plus == len_q);
    sts_o.emit_end  = (pos_plus == end_q);
    sts_o.out_free  = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign out_item_o     = item_q;
  assign out_has_item_o = has_item_q;
  assign out_status_o   = status_q;
  assign out_last_o     = last_q;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CAP_L)
    else $error("list length beyond capacity");

  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !has_item_q) |-> (item_q == '0 && last_q))
    else $error("status beat carries an item or lacks last");
`endif

endmodule

FILE: src/bdq_ctrl.sv
// Controller: sequences each operation over the datapath.
module bdq_ctrl import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RESP, S_SCAN_RD, S_SCAN_CMP,
    S_SHIFT_RD, S_SHIFT_WR, S_EMIT_RD, S_EMIT_OUT
  } state_e;

  state_e  state_q, state_d;
  status_e resp_q, resp_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '{latch: 1'b0, rd_en: 1'b0, rd_next: 1'b0, wr_sel: WR_NONE,
                len_op: LEN_HOLD, front_op: FR_HOLD, pos_op: POS_HOLD,
                out_load: 1'b0, out_entry: 1'b0, out_status: ST_OK};
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_d = S_RESP;
        resp_d  = ST_OK;
        unique case (sts_i.kind) inside
          OP_ADD_FRONT: begin
            if (sts_i.full) begin
              resp_d = ST_FULL;
            end else begin
              cmd_o.wr_sel   = WR_FRONT;
              cmd_o.front_op = FR_DEC;
              cmd_o.len_op   = LEN_INC;
            end
          end
          OP_ADD_BACK: begin
            if (sts_i.full) begin
              resp_d = ST_FULL;
            end else begin
              cmd_o.wr_sel = WR_BACK;
              cmd_o.len_op = LEN_INC;
            end
          end
          OP_DEL_VALUE: begin
            if (sts_i.empty) begin
              resp_d = ST_EMPTY;
            end else begin
              cmd_o.pos_op = POS_ZERO;
              state_d      = S_SCAN_RD;
            end
          end
          OP_DEL_FIRST: begin
            if (sts_i.empty) begin
              resp_d = ST_EMPTY;
            end else begin
              cmd_o.front_op = FR_INC;
              cmd_o.len_op   = LEN_DEC;
            end
          end
          OP_DEL_LAST: begin
            if (sts_i.empty) begin
              resp_d = ST_EMPTY;
            end else begin
              cmd_o.len_op = LEN_DEC;
            end
          end
          OP_EMIT_FIRST, OP_EMIT_LAST, OP_EMIT_ALL: begin
            cmd_o.pos_op = POS_EMIT;
            if (sts_i.emit_none) begin
              resp_d = sts_i.empty ? ST_EMPTY : ST_OK;
            end else begin
              state_d = S_EMIT_RD;
            end
          end
          OP_CLEAR: begin
            cmd_o.len_op   = LEN_CLR;
            cmd_o.front_op = FR_CLR;
          end
          default: resp_d = ST_OK;
        endcase
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          state_d          = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          if (sts_i.pos_zero) begin
            cmd_o.front_op = FR_INC;
            cmd_o.len_op   = LEN_DEC;
            resp_d         = ST_OK;
            state_d        = S_RESP;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else if (sts_i.scan_end) begin
          resp_d  = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          cmd_o.pos_op = POS_INC;
          state_d      = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.scan_end) begin
          cmd_o.len_op = LEN_DEC;
          resp_d       = ST_OK;
          state_d      = S_RESP;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.pos_op = POS_INC;
        state_d      = S_SHIFT_RD;
      end
      S_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_entry = 1'b1;
          cmd_o.pos_op    = POS_INC;
          state_d         = sts_i.emit_end ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISPATCH))
    else $error("accepted beat not dispatched");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result register overwritten while held");
`endif

endmodule

FILE: src/bounded_deque_with_delete_by_value_unit.sv
// Top level of the bounded deque with delete-by-value.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_kind_i, in_value_i, in_count_i
//  out     | output    | out_valid_o/out_stall_i | out_item_o, out_has_item_o,
//          |           |                         | out_status_o, out_last_o
//
// Sequence: add, delete first/last, clear and unused kinds pass through accept,
//   dispatch and response. Delete by value reads then compares each entry
//   scanned, and reads then writes each entry moved to close the gap; scanned
//   plus moved never exceeds the length. Emits read then send each entry after
//   accept and dispatch; the registered read port of the entry RAM is why each
//   entry needs its own read step.
// Reset: rst_ni clears front, length and control state at once; the entry RAM
//   is not cleared since only entries inside the list are ever read.
// Stalls: a result waits in the output register; the next input beat is taken
//   while it waits, and the sequence pauses only when a new result needs that
//   register.
module bounded_deque_with_delete_by_value_unit import bdq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         in_kind_i,
  input  logic signed [31:0] in_value_i,
  input  logic [6:0]         in_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_item_o,
  output logic               out_has_item_o,
  output logic [1:0]         out_status_o,
  output logic               out_last_o
);

  cmd_t cmd;   // sequencing commands
  sts_t sts;   // datapath flags

  bdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bdq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_kind_i     (in_kind_i),
    .in_value_i    (in_value_i),
    .in_count_i    (in_count_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o),
    .out_has_item_o(out_has_item_o),
    .out_status_o  (out_status_o),
    .out_last_o    (out_last_o)
  );

endmodule

FILE: bench/bounded_deque_with_delete_by_value_unit_tb.sv
// Self-checking testbench for the bounded deque with delete-by-value unit.
`timescale 1ns / 100ps

module bounded_deque_with_delete_by_value_unit_tb;
  import bdq_pkg::*;

  localparam int DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_SEGMENTS = 6;
  localparam int SEGMENT_OPS = 40;
  // kinds past clear carry no operation; the unit must answer them with OK
  localparam logic [3:0] KIND_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] KIND_UNUSED_LAST = 4'hf;
  localparam logic [6:0] COUNT_MAX = 7'h7f;

  // one result beat as the unit presents it
  typedef struct packed {
    logic [31:0] item;
    logic        has_item;
    logic [1:0]  status;
    logic        last;
  } deque_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         in_kind_i = OP_CLEAR;
  logic signed [31:0] in_value_i = '0;
  logic [6:0]         in_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] out_item_o;
  logic               out_has_item_o;
  logic [1:0]         out_status_o;
  logic               out_last_o;

  // shadow copy of the list: circular store, front slot and length
  logic [31:0]   shadow_mem [DEPTH];
  int unsigned   shadow_front = 0;
  int unsigned   shadow_len = 0;
  deque_result_t pending_results [$];
  deque_result_t want;

  // knobs for idling on each side
  bit          tx_jitter = 1'b0;
  bit          rx_jitter = 1'b0;
  int unsigned stall_left = 0;
  int unsigned hold_off_left = 0;

  int unsigned err_cnt = 0;
  int unsigned ops_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned entries_seen = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned cycle_cnt = 0;

  bounded_deque_with_delete_by_value_unit #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_kind_i      (in_kind_i),
    .in_value_i     (in_value_i),
    .in_count_i     (in_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o),
    .out_has_item_o (out_has_item_o),
    .out_status_o   (out_status_o),
    .out_last_o     (out_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length for both sides: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic int unsigned slot_of(int unsigned pos);
    return (shadow_front + pos) % DEPTH;
  endfunction

  // Apply one accepted operation to the shadow list and queue the beats it
  // must produce. Emits with entries to send give them front to back; all else,
  // an emit with nothing to send included, answers with a single status beat.
  task automatic predict_results(input logic [3:0] kind, input logic [31:0] val,
                                 input logic [6:0] cnt);
    int unsigned k, n, start, pos, j;
    bit          emits;
    logic [1:0]  st;
    k = (cnt > DEPTH) ? DEPTH : cnt;
    if (k > shadow_len) k = shadow_len;
    emits = 1'b0;
    st = ST_OK;
    start = 0;
    n = 0;
    case (kind) inside
      OP_ADD_FRONT, OP_ADD_BACK: begin
        if (shadow_len >= DEPTH) begin
          st = ST_FULL;
        end else begin
          if (kind == OP_ADD_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_mem[shadow_front] = val;
          end else begin
            shadow_mem[slot_of(shadow_len)] = val;
          end
          shadow_len++;
        end
      end
      OP_DEL_VALUE: begin
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_len && shadow_mem[slot_of(pos)] != val) pos++;
          if (pos == shadow_len) begin
            st = ST_NOT_FOUND;
          end else begin
            // a front hit just moves the front; otherwise the tail closes up
            if (pos == 0) shadow_front = slot_of(1);
            else
              for (j = pos; j + 1 < shadow_len; j++)
                shadow_mem[slot_of(j)] = shadow_mem[slot_of(j + 1)];
            shadow_len--;
          end
        end
      end
      OP_DEL_FIRST: begin
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else begin
          shadow_front = slot_of(1);
          shadow_len--;
        end
      end
      OP_DEL_LAST: begin
        if (shadow_len == 0) st = ST_EMPTY;
        else shadow_len--;
      end
      OP_EMIT_FIRST: begin
        emits = 1'b1;
        n = k;
      end
      OP_EMIT_LAST: begin
        emits = 1'b1;
        start = shadow_len - k;
        n = k;
      end
      OP_EMIT_ALL: begin
        emits = 1'b1;
        n = shadow_len;
      end
      OP_CLEAR: begin
        shadow_len = 0;
        shadow_front = 0;
      end
      default: ;
    endcase
    if (emits && n > 0) begin
      for (j = 0; j < n; j++)
        pending_results.push_back(deque_result_t'{shadow_mem[slot_of(start + j)], 1'b1,
                                                  ST_OK, (j + 1 == n)});
    end else begin
      // an emit with nothing to send says EMPTY only if the list is empty
      pending_results.push_back(deque_result_t'{32'd0, 1'b0,
                                                (emits && shadow_len == 0) ? ST_EMPTY : st,
                                                1'b1});
    end
  endtask

  // Offer one operation and hold it until the unit takes it. Valid is only
  // lowered when a gap is wanted, so back-to-back beats keep it high.
  task automatic send_op(input logic [3:0] kind, input logic [31:0] val,
                         input logic [6:0] cnt);
    int unsigned gap;
    gap = tx_jitter ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_value_i <= val;
    in_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_results(kind, val, cnt);
    ops_sent++;
  endtask

  // Mostly a handful of small values so duplicates and matches are common.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 70) return $urandom_range(16) - 8;
    return $urandom();
  endfunction

  // Receiver side: a requested hold-off wins, otherwise random stall runs.
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (rx_jitter && $urandom_range(3) == 0) stall_left = idle_len() + 1;
    end
  end

  // Result checker: every taken beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: item %0d status %0d", out_item_o, out_status_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (want.has_item) entries_seen++;
        if (out_item_o !== want.item) begin
          $error("item mismatch: expected %0d, actual %0d", $signed(want.item), out_item_o);
          err_cnt++;
        end
        if (out_has_item_o !== want.has_item) begin
          $error("has_item mismatch: expected %0d, actual %0d", want.has_item,
                 out_has_item_o);
          err_cnt++;
        end
        if (out_status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status_o);
          err_cnt++;
        end
        if (out_last_o !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_last_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog and input back-pressure statistics.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni && in_valid_i && in_stall_o === 1'b1) in_stall_cycles++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Every delete plus emit-first and emit-last on an empty list, plus a zero-length emit.
  task automatic test_empty_list();
    send_op(OP_DEL_VALUE, 32'd0, 7'd0);
    send_op(OP_DEL_FIRST, 32'd0, 7'd0);
    send_op(OP_DEL_LAST, 32'd0, 7'd0);
    send_op(OP_EMIT_FIRST, 32'd0, 7'd5);
    send_op(OP_EMIT_LAST, 32'd0, 7'd0);
    send_op(OP_CLEAR, 32'd0, 7'd0);
  endtask

  // Extreme values, count saturation and delete-by-value at front, middle
  // and back of the list.
  task automatic test_edges();
    send_op(OP_ADD_BACK, 32'h7fff_ffff, 7'd0);
    send_op(OP_ADD_FRONT, 32'h8000_0000, COUNT_MAX);
    send_op(OP_ADD_BACK, 32'hffff_ffff, 7'd0);
    send_op(OP_ADD_FRONT, 32'd0, 7'd0);
    send_op(OP_ADD_BACK, 32'd5, 7'd0);
    send_op(OP_ADD_BACK, 32'd0, 7'd0);
    send_op(OP_EMIT_FIRST, 32'd0, 7'd0);      // k of zero on a filled list
    send_op(OP_EMIT_FIRST, 32'd0, COUNT_MAX); // saturates to the length
    send_op(OP_EMIT_LAST, 32'd0, 7'd3);
    send_op(OP_EMIT_LAST, 32'd0, 7'd64);
    send_op(OP_DEL_VALUE, 32'd12345, 7'd0);   // no match
    send_op(OP_DEL_VALUE, 32'd0, 7'd0);       // front entry matches first
    send_op(OP_DEL_VALUE, 32'hffff_ffff, 7'd0);
    send_op(OP_DEL_VALUE, 32'd0, 7'd0);       // now the back entry
    send_op(OP_DEL_FIRST, 32'd0, 7'd0);
    send_op(OP_DEL_LAST, 32'd0, 7'd0);
    send_op(OP_EMIT_ALL, 32'd0, 7'd0);
    send_op(OP_CLEAR, 32'd0, 7'd0);
    send_op(OP_EMIT_ALL, 32'd0, 7'd0);
    send_op(KIND_UNUSED_LAST, 32'hffff_ffff, COUNT_MAX);
  endtask

  // Receiver holds off while adds keep coming: the list fills, the extra
  // adds come back FULL and the unit has to stall its input.
  task automatic test_backpressure();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (DEPTH + 4) begin
      if ($urandom_range(1)) send_op(OP_ADD_BACK, pick_value(), 7'd0);
      else send_op(OP_ADD_FRONT, pick_value(), 7'd0);
    end
    rx_jitter = 1'b1;
    send_op(OP_EMIT_ALL, 32'd0, 7'd0);
    send_op(OP_DEL_VALUE, shadow_mem[slot_of(DEPTH / 2)], 7'd0);
    send_op(OP_EMIT_LAST, 32'd0, COUNT_MAX);
  endtask

  // Random mix in segments that switch idling on and off for each side.
  // Deletes mostly aim at values that are really in the list.
  task automatic test_random_mix();
    int unsigned r;
    logic [31:0] val;
    logic [6:0]  cnt;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      tx_jitter = (seg != 1) && (seg != 3);
      rx_jitter = (seg != 1) && (seg != 2);
      repeat (SEGMENT_OPS) begin
        r = $urandom_range(99);
        cnt = ($urandom_range(99) < 80) ? 7'($urandom_range(DEPTH + 4))
                                        : 7'($urandom_range(COUNT_MAX));
        if (shadow_len > 0 && $urandom_range(99) < 70)
          val = shadow_mem[slot_of($urandom_range(shadow_len - 1))];
        else
          val = pick_value();
        if (r < 22) send_op(OP_ADD_BACK, pick_value(), cnt);
        else if (r < 40) send_op(OP_ADD_FRONT, pick_value(), cnt);
        else if (r < 58) send_op(OP_DEL_VALUE, val, cnt);
        else if (r < 66) send_op(OP_DEL_FIRST, val, cnt);
        else if (r < 74) send_op(OP_DEL_LAST, val, cnt);
        else if (r < 82) send_op(OP_EMIT_FIRST, val, cnt);
        else if (r < 89) send_op(OP_EMIT_LAST, val, cnt);
        else if (r < 95) send_op(OP_EMIT_ALL, val, cnt);
        else if (r < 97) send_op(OP_CLEAR, val, cnt);
        else send_op(KIND_UNUSED_FIRST
                     + 4'($urandom_range(KIND_UNUSED_LAST - KIND_UNUSED_FIRST)),
                     pick_value(), cnt);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    test_edges();
    test_backpressure();
    test_random_mix();

    // drain: stop stalling and let every expected beat arrive
    in_valid_i <= 1'b0;
    rx_jitter = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d operations, %0d result beats (%0d list entries) checked",
             ops_sent, beats_checked, entries_seen);
    $display("input held off for %0d cycles; %0d mismatches", in_stall_cycles, err_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: bounded_deque_with_delete_by_value_unit.f
src/bdq_pkg.sv
src/bdq_ram.sv
src/bdq_datapath.sv
src/bdq_ctrl.sv
src/bounded_deque_with_delete_by_value_unit.sv
bench/bounded_deque_with_delete_by_value_unit_tb.sv
